// File: hdl/eitsf_pkg.sv
`timescale 1ns / 1ps

package eitsf_pkg;

    // fixed store geometry
    localparam int TABLE_SLOTS       = 17;
    localparam int SECTION_SLOTS     = 256;
    localparam int MAX_SECTION_BYTES = 4096;
    localparam int STORE_DEPTH       = TABLE_SLOTS * SECTION_SLOTS;
    localparam int STORE_AW          = $clog2(STORE_DEPTH);
    localparam int SLOT_W            = 5;
    localparam int SECNUM_W          = 8;

    // queue depths between the parts
    localparam int DESC_FIFO_DEPTH   = 4;
    localparam int RES_FIFO_DEPTH    = 2;

    localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [7:0]  TID_EIT_PF    = 8'h4E;
    localparam logic [7:0]  TID_SCHED_LO  = 8'h50;
    localparam logic [7:0]  TID_SCHED_HI  = 8'h5F;
    localparam logic [7:0]  CURRENT_MASK  = 8'h01;
    localparam int          MIN_SECTION_BYTES = 18;

    // configuration register indexes
    localparam logic CFG_FILTER_ENABLE = 1'b0;
    localparam logic CFG_SERVICE_MATCH = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_NEW     = 3'd0,
        VERDICT_SHORT   = 3'd1,
        VERDICT_TABLE   = 3'd2,
        VERDICT_NOT_CUR = 3'd3,
        VERDICT_SERVICE = 3'd4,
        VERDICT_CRC     = 3'd5,
        VERDICT_DUP     = 3'd6
    } verdict_t;

    // finished section, handed from front to back
    typedef struct packed {
        verdict_t              verdict;   // VERDICT_NEW means store lookup pending
        logic [SLOT_W-1:0]     slot;
        logic [SECNUM_W-1:0]   section_num;
        logic [15:0]           service;
        logic [31:0]           tail;
    } desc_t;

    typedef struct packed {
        verdict_t              verdict;
        logic [SLOT_W-1:0]     slot;
        logic [SECNUM_W-1:0]   section_num;
        logic [15:0]           service;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {b, 24'h0};
        for (int i = 0; i < 8; i++)
        begin
            if (c[31])
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: hdl/eit_section_filter.sv
`timescale 1ns / 1ps

// path: a section result, from its last byte transfer, goes through the section
//   queue, the store read when the lookup runs, then the output queue; other bytes give none
// throughput: one byte per cycle unless full; back end: a rejected section per
//   cycle if results fit, an accepted one by store read, then compare and write
// reset: full stays high after rst_n rises while the seen-crc store is swept to
//   zero; configuration writes are taken during the sweep
module eit_section_filter
    import eitsf_pkg::*;
#(
    parameter int MAX_BYTES = MAX_SECTION_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wr_data,
    // section bytes
    input  logic        push,
    output logic        full,
    input  logic [7:0]  section_byte,
    input  logic        last_byte,
    // results
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  verdict,
    output logic [4:0]  table_slot,
    output logic [7:0]  section_index,
    output logic [15:0] service_seen
);

    logic        filter_enable_reg;
    logic [15:0] service_match_reg;

    logic        accept;
    logic        desc_push, desc_pop, desc_empty, desc_full;
    desc_t       desc_in, desc_out;
    logic        res_push, res_full;
    result_t     res_in, res_out;
    logic        clearing;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            service_match_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_FILTER_ENABLE: filter_enable_reg <= cfg_wr_data[0];
                CFG_SERVICE_MATCH: service_match_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // stall input while the store sweep runs or the section queue is full
    assign full   = clearing || desc_full;
    assign accept = push && !full;

    // front: crc, header capture and checks over the incoming bytes
    eitsf_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .section_byte  (section_byte),
        .last_byte     (last_byte),
        .filter_enable (filter_enable_reg),
        .service_match (service_match_reg),
        .desc_push     (desc_push),
        .desc          (desc_in)
    );

    // finished sections waiting for the back end
    eitsf_fifo #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (DESC_FIFO_DEPTH)
    ) u_desc_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (desc_push),
        .din   (desc_in),
        .pop   (desc_pop),
        .dout  (desc_out),
        .empty (desc_empty),
        .full  (desc_full)
    );

    // back: duplicate check against the per slot and section crc store
    eitsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (!desc_empty),
        .desc       (desc_out),
        .desc_pop   (desc_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in),
        .clearing   (clearing)
    );

    // output queue, lets the back end go on while a result waits for transfer
    eitsf_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_FIFO_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty),
        .full  (res_full)
    );

    assign verdict       = res_out.verdict;
    assign table_slot    = res_out.slot;
    assign section_index = res_out.section_num;
    assign service_seen  = res_out.service;

endmodule

// File: hdl/eitsf_ram.sv
`timescale 1ns / 1ps

module eitsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4352
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/eitsf_fifo.sv
`timescale 1ns / 1ps

module eitsf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end

endmodule

// File: hdl/eitsf_front.sv
`timescale 1ns / 1ps

module eitsf_front
    import eitsf_pkg::*;
#(
    parameter int MAX_BYTES = MAX_SECTION_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  section_byte,
    input  logic        last_byte,
    input  logic        filter_enable,
    input  logic [15:0] service_match,
    output logic        desc_push,
    output desc_t       desc
);

    localparam int CW = $clog2(MAX_BYTES + 1);

    logic [31:0]   crc_reg, crc_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    tid_reg, tid_next;
    logic          cur_reg, cur_next;
    logic [15:0]   svc_reg, svc_next;
    logic [7:0]    secnum_reg, secnum_next;
    logic [31:0]   tail_reg, tail_next;
    logic          slot_ok;
    logic [SLOT_W-1:0] slot;
    logic [7:0]    tid_off;

    // running values including the byte being taken
    always_comb
    begin
        tid_next    = tid_reg;
        svc_next    = svc_reg;
        cur_next    = cur_reg;
        secnum_next = secnum_reg;
        case (count_reg)
            CW'(0):  tid_next = section_byte;
            CW'(3):  svc_next = {section_byte, svc_reg[7:0]};
            CW'(4):  svc_next = {svc_reg[15:8], section_byte};
            CW'(5):  cur_next = |(section_byte & CURRENT_MASK);
            CW'(6):  secnum_next = section_byte;
            default: ;
        endcase
        crc_next   = crc_byte(crc_reg, section_byte);
        tail_next  = {tail_reg[23:0], section_byte};
        count_next = (count_reg < CW'(MAX_BYTES)) ? count_reg + 1'b1 : count_reg;
    end

    // table slot and verdict before the store lookup
    always_comb
    begin
        tid_off = tid_next - TID_SCHED_LO;
        slot    = '0;
        slot_ok = 1'b0;
        if (tid_next == TID_EIT_PF)
            slot_ok = 1'b1;
        else if (tid_next >= TID_SCHED_LO && tid_next <= TID_SCHED_HI)
        begin
            slot_ok = 1'b1;
            slot    = SLOT_W'(tid_off[3:0]) + 1'b1;
        end

        desc.slot        = slot;
        desc.section_num = secnum_next;
        desc.service     = svc_next;
        desc.tail        = tail_next;
        if (count_next < CW'(MIN_SECTION_BYTES))
            desc.verdict = VERDICT_SHORT;
        else if (!slot_ok)
            desc.verdict = VERDICT_TABLE;
        else if (!cur_next)
            desc.verdict = VERDICT_NOT_CUR;
        else if (filter_enable && svc_next != service_match)
            desc.verdict = VERDICT_SERVICE;
        else if (crc_next != '0)
            desc.verdict = VERDICT_CRC;
        else
            desc.verdict = VERDICT_NEW;
    end

    assign desc_push = accept && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= CRC_INIT;
            count_reg  <= '0;
            tid_reg    <= '0;
            cur_reg    <= 1'b0;
            svc_reg    <= '0;
            secnum_reg <= '0;
            tail_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                crc_reg    <= CRC_INIT;
                count_reg  <= '0;
                tid_reg    <= '0;
                cur_reg    <= 1'b0;
                svc_reg    <= '0;
                secnum_reg <= '0;
                tail_reg   <= '0;
            end
            else
            begin
                crc_reg    <= crc_next;
                count_reg  <= count_next;
                tid_reg    <= tid_next;
                cur_reg    <= cur_next;
                svc_reg    <= svc_next;
                secnum_reg <= secnum_next;
                tail_reg   <= tail_next;
            end
        end
    end

endmodule

// File: hdl/eitsf_back.sv
`timescale 1ns / 1ps

module eitsf_back
    import eitsf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    desc_valid,
    input  desc_t   desc,
    output logic    desc_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res,
    output logic    clearing
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t              state_reg, state_next;
    logic [STORE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    desc_t               hold_reg, hold_next;

    logic                wr_en, rd_en;
    logic [STORE_AW-1:0] wr_addr, rd_addr;
    logic [31:0]         wr_data, rd_data;

    eitsf_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        hold_next    = hold_reg;
        wr_en        = 1'b0;
        wr_addr      = {hold_reg.slot, hold_reg.section_num};
        wr_data      = hold_reg.tail;
        rd_en        = 1'b0;
        rd_addr      = {desc.slot, desc.section_num};
        desc_pop     = 1'b0;
        res_push     = 1'b0;
        res.verdict     = desc.verdict;
        res.slot        = desc.slot;
        res.section_num = desc.section_num;
        res.service     = desc.service;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == STORE_AW'(STORE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (desc_valid && !res_full)
                begin
                    desc_pop = 1'b1;
                    if (desc.verdict == VERDICT_NEW)
                    begin
                        rd_en      = 1'b1;
                        hold_next  = desc;
                        state_next = ST_LOOK;
                    end
                    else
                        res_push = 1'b1;
                end
            end
            ST_LOOK:
            begin
                // result space was checked when the lookup started
                res_push        = 1'b1;
                res.slot        = hold_reg.slot;
                res.section_num = hold_reg.section_num;
                res.service     = hold_reg.service;
                if (rd_data == hold_reg.tail)
                    res.verdict = VERDICT_DUP;
                else
                begin
                    res.verdict = VERDICT_NEW;
                    wr_en       = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign clearing = (state_reg == ST_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule
